// File: hdl/floor_ceiling_texture_coords_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the floor and ceiling texture coordinate generator
// Short forms for same-cycle and next-cycle implications on i_clk.
// ----------------------------------------------------------------------------
`ifndef FLOOR_CEILING_TEXTURE_COORDS_MACROS_SVH
`define FLOOR_CEILING_TEXTURE_COORDS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCTC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FCTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/fctc_pkg.sv
// ----------------------------------------------------------------------------
// Floor and ceiling texture coordinates: shared package
// Beat types, field widths, register indexes and datapath widths.
// ----------------------------------------------------------------------------
`default_nettype none

package fctc_pkg;

    // Field widths of the beats.
    localparam int ROW_W = 10;
    localparam int COL_W = 11;
    localparam int TEX_W = 6;

    // Configuration register widths.
    localparam int POS_W      = 24;
    localparam int DIR_W      = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Datapath widths, sized for the largest supported screen.
    localparam int ACC_W  = 40;
    localparam int FRAC_W = 16;
    localparam int DIST_W = 26;
    localparam int OPS_W  = 20;
    localparam int MAG_W  = 19;
    localparam int PROD_W = DIST_W + MAG_W;
    localparam int DVS_W  = 28;

    // Reset values of the direction registers.
    localparam logic signed [DIR_W-1:0] VIEW_X_RST  = 18'sd65536;
    localparam logic signed [DIR_W-1:0] PLANE_Y_RST = 18'sd43254;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLAYER_POS_X   = 3'd0,
        REG_PLAYER_POS_Y   = 3'd1,
        REG_VIEW_DIR_X     = 3'd2,
        REG_VIEW_DIR_Y     = 3'd3,
        REG_CAMERA_PLANE_X = 3'd4,
        REG_CAMERA_PLANE_Y = 3'd5
    } t_cfg_reg;

    // One screen pixel in.
    typedef struct packed {
        logic [ROW_W-1:0] screen_row;
        logic [COL_W-1:0] screen_column;
    } t_pix_in;

    // One coordinate result out.
    typedef struct packed {
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
        logic [ROW_W-1:0] ceiling_row;
        logic [ROW_W-1:0] floor_row;
        logic [COL_W-1:0] pixel_column;
        logic             horizon_flag;
    } t_pix_out;

endpackage

`default_nettype wire

// File: hdl/fctc_div.sv
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module fctc_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [fctc_pkg::PROD_W-1:0] i_dividend,
    input  wire logic [fctc_pkg::DVS_W-1:0]  i_divisor,
    output logic                             o_done,
    output logic [fctc_pkg::PROD_W-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(fctc_pkg::PROD_W);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [fctc_pkg::PROD_W-1:0]   r_quo;
    logic [fctc_pkg::DVS_W-1:0]    r_rem;
    logic [fctc_pkg::DVS_W-1:0]    r_dvs;

    logic [fctc_pkg::DVS_W:0]      w_trial;
    logic                          w_ge;
    logic [fctc_pkg::DVS_W-1:0]    w_rem_next;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    always_comb begin
        w_trial    = {r_rem, r_quo[fctc_pkg::PROD_W-1]};
        w_ge       = (w_trial >= {1'b0, r_dvs});
        w_rem_next = w_ge ? fctc_pkg::DVS_W'(w_trial - {1'b0, r_dvs})
                          : fctc_pkg::DVS_W'(w_trial);
    end

    // Sequencing of the division steps; the quotient grows in the dividend's place.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(fctc_pkg::PROD_W - 1);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_rem_next;
                r_quo <= {r_quo[fctc_pkg::PROD_W-2:0], w_ge};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// File: hdl/fctc_mul.sv
// ----------------------------------------------------------------------------
// Registered magnitude multiplier
// Row distance magnitude times operand magnitude, result in the following cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fctc_mul (
    input  wire logic                        i_clk,
    input  wire logic [fctc_pkg::DIST_W-1:0] i_a,
    input  wire logic [fctc_pkg::MAG_W-1:0]  i_b,
    output logic [fctc_pkg::PROD_W-1:0]      o_prod
);

    logic [fctc_pkg::PROD_W-1:0] r_prod;

    // The product is registered before anything else uses it.
    always_ff @(posedge i_clk) begin
        r_prod <= fctc_pkg::PROD_W'(i_a) * fctc_pkg::PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// File: hdl/floor_ceiling_texture_coords.sv
// Output: a pixel with a nonzero column is written to the output register on acceptance, or
// waits in S_EMIT while that register is full. Throughput: such pixels stream at one per cycle
// while the output side takes each beat; the output register parts the two sides. A column 0
// pixel sets up its row through three passes through the one-bit-per-cycle divider and four
// passes through the shared multiplier. The horizon row needs no arithmetic.
// Reset (synchronous, active low) restores register defaults and clears the accumulators.
// ----------------------------------------------------------------------------
// Floor and ceiling texture coordinate generator
// Row setup by a small sequencer over a shared divider and multiplier,
// then per-pixel texture coordinates from the world position accumulators.
// ----------------------------------------------------------------------------
`default_nettype none
`include "floor_ceiling_texture_coords_macros.svh"

module floor_ceiling_texture_coords #(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 768,
    parameter int TEXTURE_SIZE  = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire fctc_pkg::t_pix_in               i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output fctc_pkg::t_pix_out                   o_out_data,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [fctc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fctc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ROW_W  = fctc_pkg::ROW_W;
    localparam int COL_W  = fctc_pkg::COL_W;
    localparam int TEX_W  = fctc_pkg::TEX_W;
    localparam int ACC_W  = fctc_pkg::ACC_W;
    localparam int FRAC_W = fctc_pkg::FRAC_W;
    localparam int DIST_W = fctc_pkg::DIST_W;
    localparam int OPS_W  = fctc_pkg::OPS_W;
    localparam int MAG_W  = fctc_pkg::MAG_W;
    localparam int PROD_W = fctc_pkg::PROD_W;
    localparam int DVS_W  = fctc_pkg::DVS_W;
    localparam int DIR_W  = fctc_pkg::DIR_W;
    localparam int POS_W  = fctc_pkg::POS_W;

    localparam int                 TEX_SHIFT  = FRAC_W - $clog2(TEXTURE_SIZE);
    localparam logic [TEX_W-1:0]   TEX_MASK   = TEX_W'(TEXTURE_SIZE - 1);
    localparam logic [ROW_W:0]     HALF_H     = (ROW_W + 1)'(SCREEN_HEIGHT / 2);
    localparam logic [ROW_W-1:0]   FLOOR_BASE = ROW_W'(SCREEN_HEIGHT - 1);
    localparam logic [DIST_W-1:0]  POS_Z      = DIST_W'(SCREEN_HEIGHT * 32768);
    localparam logic [DVS_W-1:0]   W_DIV      = DVS_W'(SCREEN_WIDTH * 65536);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIST,
        S_MUL,
        S_PROD,
        S_DIVS,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        OP_WX,
        OP_WY,
        OP_SX,
        OP_SY
    } t_op;

    // Texture coordinate from the fraction of a signed world position.
    function automatic logic [TEX_W-1:0] tex_coord(input logic [ACC_W-1:0] w);
        logic [FRAC_W-1:0] f;
        logic [TEX_W-1:0]  t;
        f = w[ACC_W-1] ? FRAC_W'(~w[FRAC_W-1:0] + FRAC_W'(1)) : w[FRAC_W-1:0];
        t = TEX_W'(f >> TEX_SHIFT);
        if (w[ACC_W-1]) begin
            t = TEX_W'(0) - t;
        end
        return t & TEX_MASK;
    endfunction

    // Configuration registers.
    logic [POS_W-1:0]        r_pos_x;
    logic [POS_W-1:0]        r_pos_y;
    logic [DIR_W-1:0]        r_view_x;
    logic [DIR_W-1:0]        r_view_y;
    logic [DIR_W-1:0]        r_plane_x;
    logic [DIR_W-1:0]        r_plane_y;

    // Sequencer and row state.
    t_state                  r_state;
    t_op                     r_op;
    logic [ROW_W-1:0]        r_row;
    logic [COL_W-1:0]        r_col;
    logic [DIST_W-1:0]       r_dist_mag;
    logic                    r_dist_neg;
    logic [ACC_W-1:0]        r_acc_x;
    logic [ACC_W-1:0]        r_acc_y;
    logic [ACC_W-1:0]        r_step_x;
    logic [ACC_W-1:0]        r_step_y;
    logic                    r_horizon;
    logic                    r_out_valid;
    fctc_pkg::t_pix_out      r_out;

    logic                    w_in_acc;
    logic                    w_out_free;
    logic                    w_emit;
    logic [ROW_W-1:0]        w_emit_row;
    logic [COL_W-1:0]        w_emit_col;
    logic [ROW_W:0]          w_position;
    logic                    w_pos_neg;
    logic [ROW_W-1:0]        w_pos_mag;
    logic [OPS_W-1:0]        w_dx0;
    logic [OPS_W-1:0]        w_dy0;
    logic [OPS_W-1:0]        w_span_x;
    logic [OPS_W-1:0]        w_span_y;
    logic [OPS_W-1:0]        w_op_val;
    logic [MAG_W-1:0]        w_op_mag;
    logic                    w_res_neg;
    logic [PROD_W-1:0]       w_prod;
    logic [ACC_W-1:0]        w_term_abs;
    logic [ACC_W-1:0]        w_term;
    logic [ACC_W-1:0]        w_step_abs;
    logic [ACC_W-1:0]        w_step;
    logic                    w_div_start;
    logic [PROD_W-1:0]       w_div_dividend;
    logic [DVS_W-1:0]        w_div_divisor;
    logic                    w_div_done;
    logic [PROD_W-1:0]       w_div_quo;

    // Handshakes: the configuration port never stalls.
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Signed distance of the incoming row from the horizon.
    always_comb begin
        w_position = {1'b0, i_in_data.screen_row} - HALF_H;
        w_pos_neg  = w_position[ROW_W];
        w_pos_mag  = ROW_W'(w_pos_neg ? ((ROW_W + 1)'(0) - w_position) : w_position);
    end

    // Ray span operands: leftmost ray direction and the full left-to-right span.
    always_comb begin
        w_dx0    = {{2{r_view_x[DIR_W-1]}}, r_view_x} - {{2{r_plane_x[DIR_W-1]}}, r_plane_x};
        w_dy0    = {{2{r_view_y[DIR_W-1]}}, r_view_y} - {{2{r_plane_y[DIR_W-1]}}, r_plane_y};
        w_span_x = {r_plane_x[DIR_W-1], r_plane_x, 1'b0};
        w_span_y = {r_plane_y[DIR_W-1], r_plane_y, 1'b0};
        unique case (r_op)
            OP_WX:   w_op_val = w_dx0;
            OP_WY:   w_op_val = w_dy0;
            OP_SX:   w_op_val = w_span_x;
            OP_SY:   w_op_val = w_span_y;
            default: w_op_val = w_dx0;
        endcase
        w_op_mag  = MAG_W'(w_op_val[OPS_W-1] ? (OPS_W'(0) - w_op_val) : w_op_val);
        w_res_neg = r_dist_neg ^ w_op_val[OPS_W-1];
    end

    // Signed results rounded toward zero: start offset and per-column step.
    always_comb begin
        w_term_abs = ACC_W'(w_prod[PROD_W-1:FRAC_W]);
        w_term     = w_res_neg ? (ACC_W'(0) - w_term_abs) : w_term_abs;
        w_step_abs = ACC_W'(w_div_quo);
        w_step     = w_res_neg ? (ACC_W'(0) - w_step_abs) : w_step_abs;
    end

    // The divider serves the row distance first and then both steps.
    always_comb begin
        w_div_start    = 1'b0;
        w_div_dividend = PROD_W'(POS_Z);
        w_div_divisor  = DVS_W'(w_pos_mag);
        if (r_state == S_IDLE) begin
            w_div_start = w_in_acc && (i_in_data.screen_column == '0) &&
                          (w_pos_mag != '0);
        end else if (r_state == S_PROD && (r_op == OP_SX || r_op == OP_SY)) begin
            w_div_start    = 1'b1;
            w_div_dividend = w_prod;
            w_div_divisor  = W_DIV;
        end
    end

    // A result beat leaves when the output register is free.
    always_comb begin
        w_emit = 1'b0;
        if (r_state == S_IDLE) begin
            w_emit = w_in_acc && (i_in_data.screen_column != '0) && w_out_free;
        end else if (r_state == S_EMIT) begin
            w_emit = w_out_free;
        end
        w_emit_row = (r_state == S_IDLE) ? i_in_data.screen_row : r_row;
        w_emit_col = (r_state == S_IDLE) ? i_in_data.screen_column : r_col;
    end

    fctc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    fctc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (r_dist_mag),
        .i_b    (w_op_mag),
        .o_prod (w_prod)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_view_x  <= fctc_pkg::VIEW_X_RST;
            r_view_y  <= '0;
            r_plane_x <= '0;
            r_plane_y <= fctc_pkg::PLANE_Y_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fctc_pkg::REG_PLAYER_POS_X:   r_pos_x   <= i_cfg_data;
                fctc_pkg::REG_PLAYER_POS_Y:   r_pos_y   <= i_cfg_data;
                fctc_pkg::REG_VIEW_DIR_X:     r_view_x  <= i_cfg_data[DIR_W-1:0];
                fctc_pkg::REG_VIEW_DIR_Y:     r_view_y  <= i_cfg_data[DIR_W-1:0];
                fctc_pkg::REG_CAMERA_PLANE_X: r_plane_x <= i_cfg_data[DIR_W-1:0];
                fctc_pkg::REG_CAMERA_PLANE_Y: r_plane_y <= i_cfg_data[DIR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer, accumulators and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_WX;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_step_x    <= '0;
            r_step_y    <= '0;
            r_horizon   <= 1'b0;
            r_dist_neg  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_row <= i_in_data.screen_row;
                r_col <= i_in_data.screen_column;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_in_data.screen_column == '0) begin
                            if (w_pos_mag == '0) begin
                                r_horizon <= 1'b1;
                                r_acc_x   <= '0;
                                r_acc_y   <= '0;
                                r_step_x  <= '0;
                                r_step_y  <= '0;
                                r_state   <= S_EMIT;
                            end else begin
                                r_horizon  <= 1'b0;
                                r_dist_neg <= w_pos_neg;
                                r_state    <= S_DIST;
                            end
                        end else if (!w_out_free) begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_DIST: begin
                    if (w_div_done) begin
                        r_dist_mag <= DIST_W'(w_div_quo);
                        r_op       <= OP_WX;
                        r_state    <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_PROD;
                end
                S_PROD: begin
                    unique case (r_op)
                        OP_WX: begin
                            r_acc_x <= ACC_W'(r_pos_x) + w_term;
                            r_op    <= OP_WY;
                            r_state <= S_MUL;
                        end
                        OP_WY: begin
                            r_acc_y <= ACC_W'(r_pos_y) + w_term;
                            r_op    <= OP_SX;
                            r_state <= S_MUL;
                        end
                        OP_SX, OP_SY: begin
                            r_state <= S_DIVS;
                        end
                        default: begin
                            r_state <= S_DIVS;
                        end
                    endcase
                end
                S_DIVS: begin
                    if (w_div_done) begin
                        if (r_op == OP_SY) begin
                            r_step_y <= w_step;
                            r_state  <= S_EMIT;
                        end else begin
                            r_step_x <= w_step;
                            r_op     <= OP_SY;
                            r_state  <= S_MUL;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Emit a beat from the current position, then step one column on.
            if (w_emit) begin
                r_out_valid        <= 1'b1;
                r_out.tex_u        <= r_horizon ? TEX_W'(0) : tex_coord(r_acc_x);
                r_out.tex_v        <= r_horizon ? TEX_W'(0) : tex_coord(r_acc_y);
                r_out.ceiling_row  <= w_emit_row;
                r_out.floor_row    <= FLOOR_BASE - w_emit_row;
                r_out.pixel_column <= w_emit_col;
                r_out.horizon_flag <= r_horizon;
                r_acc_x            <= r_acc_x + r_step_x;
                r_acc_y            <= r_acc_y + r_step_y;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The divider only reports completion while the sequencer waits for it.
    `FCTC_ASSERT_SAME(a_div_done_waited, w_div_done, (r_state == S_DIST || r_state == S_DIVS), "divider finished while the sequencer was not waiting")

    // On the horizon row every accumulator and step stays at zero.
    `FCTC_ASSERT_SAME(a_horizon_zero, r_horizon, (r_acc_x == '0 && r_acc_y == '0 && r_step_x == '0 && r_step_y == '0), "horizon row with nonzero position or step")

    // A horizon beat carries zero texture coordinates.
    `FCTC_ASSERT_SAME(a_horizon_tex, (o_out_valid && o_out_data.horizon_flag), (o_out_data.tex_u == '0 && o_out_data.tex_v == '0), "horizon beat with nonzero texture coordinates")

    // A streamed pixel comes out on the next cycle with its own row.
    `FCTC_ASSERT_NEXT(a_stream_row, (r_state == S_IDLE && w_in_acc && i_in_data.screen_column != '0 && w_out_free), (o_out_valid && o_out_data.ceiling_row == $past(i_in_data.screen_row)), "streamed pixel lost or given the wrong row")

endmodule

`default_nettype wire
